@@ src/fbx_pkg.sv @@
// fbx_pkg: types and constants for the framed byte bus exchange controller
// used by every file of the block; no dependencies
package fbx_pkg;

	localparam int MaxFrame = 32;
	localparam int TxQueueDepth = 512;
	localparam int QAW = $clog2(TxQueueDepth);
	localparam int FAW = $clog2(MaxFrame);

	localparam logic [7:0] AckGood = 8'h0F;
	localparam logic [7:0] AckBad = 8'hF0;
	localparam logic [7:0] DataOfs = 8'h40;
	localparam logic [7:0] AckOfs = 8'h80;

	localparam logic [2:0] OpPush = 3'd0;
	localparam logic [2:0] OpSyncReq = 3'd1;
	localparam logic [2:0] OpSlot = 3'd2;
	localparam logic [2:0] OpDone = 3'd3;
	localparam logic [2:0] OpSyncByte = 3'd4;
	localparam logic [2:0] OpDataByte = 3'd5;
	localparam logic [2:0] OpBusErr = 3'd6;

	localparam logic [1:0] KindStart = 2'd0;
	localparam logic [1:0] KindTx = 2'd1;
	localparam logic [1:0] KindRx = 2'd2;

	localparam logic [1:0] MsgSync = 2'd0;
	localparam logic [1:0] MsgData = 2'd1;
	localparam logic [1:0] MsgAck = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data_byte;
		logic [4:0] byte_index;
		logic       error_in_address_phase;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] msg_type;
		logic [7:0] address;
		logic [5:0] tx_len;
		logic [5:0] rx_len;
		logic [7:0] data_byte_res;
		logic       last;
		logic       online;
		logic       start_request;
	} out_item_t;

endpackage

@@ src/framed_byte_bus_exchange_ctrl.sv @@
// framed_byte_bus_exchange_ctrl: top level, sequencer, queue and frame memories
// depends on fbx_pkg
//
//  channel   dir  handshake            payload
//  in        in   in_valid/in_ready    fbx_pkg::in_item_t
//  out       out  out_valid/out_ready  fbx_pkg::out_item_t
//  cfg       in   cfg_valid/cfg_ready  device_address (8)
//
// a sync start walks up to 31 queue bytes through one adder, one byte at a time;
// data frame and rx delivery emit their results one by one after the start, and
// the rx checksum walk reads each rx byte and then the check byte. in is not ready
// until the sequencer is idle again. out stalls hold the sequencer. reset needs no clearing pass.
module framed_byte_bus_exchange_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fbx_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fbx_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_QRD    = 10'b0000000010,
		S_QACC   = 10'b0000000100,
		S_SYNCO  = 10'b0000001000,
		S_DATAO  = 10'b0000010000,
		S_RXSUM  = 10'b0000100000,
		S_ACKO   = 10'b0001000000,
		S_RXO    = 10'b0010000000,
		S_FRD    = 10'b0100000000,
		S_HOLD   = 10'b1000000000
	} st_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_SYNC = 4'b0010,
		PH_DATA = 4'b0100,
		PH_ACK  = 4'b1000
	} ph_t;

	st_t st_q;
	ph_t ph_q;
	logic [7:0] dev_q, cur_q;
	logic [fbx_pkg::QAW:0] qcnt_q;
	logic [fbx_pkg::QAW-1:0] qhead_q;
	logic [7:0] sr0_q, sr1_q;
	logic [5:0] txc_q, rxc_q, stc_q;
	logic online_q, thisok_q, pend_q, sreq_q;
	logic [5:0] i_q, n_q;
	logic [7:0] sum_q;
	logic [1:0] sub_q;
	logic busy_q;

	logic [7:0] txq_mem [fbx_pkg::TxQueueDepth];
	logic [7:0] txf_mem [fbx_pkg::MaxFrame];
	logic [7:0] rxf_mem [fbx_pkg::MaxFrame];
	logic [7:0] qrd_q, frd_q;
	logic [fbx_pkg::QAW-1:0] qra;
	logic [fbx_pkg::FAW-1:0] fra;
	logic fsel_rx;

	fbx_pkg::out_item_t ob_q;
	logic ov_q;
	fbx_pkg::in_item_t it;

	assign it = in_data;
	assign in_ready = (st_q == S_IDLE) && !busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = ov_q;
	assign out_data = ob_q;

	wire in_xfer = in_valid && in_ready;
	wire ofree = !ov_q || out_ready;

	assign qra = qhead_q + fbx_pkg::QAW'(i_q);

	always_ff @(posedge clk) begin
		if (in_xfer && it.op == fbx_pkg::OpPush && qcnt_q < (fbx_pkg::QAW+1)'(fbx_pkg::TxQueueDepth))
			txq_mem[qhead_q + qcnt_q[fbx_pkg::QAW-1:0]] <= it.data_byte;
		if (in_xfer && it.op == fbx_pkg::OpDataByte &&
			{1'b0, it.byte_index} < 6'(fbx_pkg::MaxFrame))
			rxf_mem[it.byte_index[fbx_pkg::FAW-1:0]] <= it.data_byte;
		if (st_q == S_QACC)
			txf_mem[fbx_pkg::FAW'(i_q + 6'd1)] <= qrd_q;
		if (st_q == S_SYNCO && sub_q == 2'd0 && n_q != 6'd0)
			txf_mem[0] <= sum_q;
		qrd_q <= txq_mem[qra];
		frd_q <= fsel_rx ? rxf_mem[fra] : txf_mem[fra];
	end

	// frame read address: data walk reads tx, rx walks read rx
	// rx checksum walk uses i_q=63 as final check-byte read index (fra wraps to 0)
	always_comb begin
		fsel_rx = (st_q == S_RXSUM) || (st_q == S_RXO) || (st_q == S_HOLD) ||
			((st_q == S_FRD) && (ph_q == PH_ACK));
		fra = fbx_pkg::FAW'(i_q);
		if (fsel_rx) fra = fbx_pkg::FAW'(i_q + 6'd1);
	end

	function automatic fbx_pkg::out_item_t mk(input logic [1:0] k, input logic [1:0] t,
		input logic [7:0] a, input logic [5:0] tl, input logic [5:0] rl, input logic [7:0] b,
		input logic l, input logic on, input logic sr);
		fbx_pkg::out_item_t r;
		r.kind = k; r.msg_type = t; r.address = a; r.tx_len = tl; r.rx_len = rl;
		r.data_byte_res = b; r.last = l; r.online = on; r.start_request = sr;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ph_q <= PH_IDLE; dev_q <= 8'd0; cur_q <= 8'd0;
			qcnt_q <= '0; qhead_q <= '0; sr0_q <= 8'd0; sr1_q <= 8'd0;
			txc_q <= 6'd0; rxc_q <= 6'd0; stc_q <= 6'd0;
			online_q <= 1'b0; thisok_q <= 1'b1; pend_q <= 1'b0;
			sreq_q <= 1'b0; i_q <= 6'd0; n_q <= 6'd0; sum_q <= 8'd0; sub_q <= 2'd0;
			ov_q <= 1'b0; busy_q <= 1'b0;
		end else begin
			busy_q <= in_xfer;
			if (out_ready) ov_q <= 1'b0;
			if (cfg_valid) begin
				dev_q <= cfg_data; cur_q <= cfg_data;
			end
			case (st_q)
				S_IDLE: if (in_xfer) begin
					case (it.op)
						fbx_pkg::OpPush:
							if (qcnt_q < (fbx_pkg::QAW+1)'(fbx_pkg::TxQueueDepth))
								qcnt_q <= qcnt_q + 1'b1;
						fbx_pkg::OpSyncReq: begin pend_q <= 1'b1; sreq_q <= 1'b1; end
						fbx_pkg::OpSlot:
							if (ph_q == PH_IDLE && pend_q) begin
								pend_q <= 1'b0; sreq_q <= 1'b0;
								cur_q <= dev_q;
								if (txc_q == 6'd0 || thisok_q) begin
									thisok_q <= 1'b0;
									n_q <= (qcnt_q > (fbx_pkg::QAW+1)'(fbx_pkg::MaxFrame-1))
										? 6'(fbx_pkg::MaxFrame-1) : 6'(qcnt_q);
									i_q <= 6'd0; sum_q <= 8'd1;
									st_q <= S_QRD;
								end else begin
									txc_q <= stc_q; n_q <= stc_q;
									sub_q <= 2'd1; st_q <= S_SYNCO;
								end
							end else sreq_q <= pend_q;
						fbx_pkg::OpDone:
							case (ph_q)
								PH_SYNC: begin
									online_q <= 1'b1;
									rxc_q <= (sr1_q > 8'(fbx_pkg::MaxFrame-1)) ?
										6'(fbx_pkg::MaxFrame-1) : 6'(sr1_q);
									ph_q <= PH_IDLE;
									if (8'(sr1_q + 8'd1) == sr0_q) begin
										if (sr1_q != 8'd0 || txc_q != 6'd0) begin
											ph_q <= PH_DATA; cur_q <= dev_q + fbx_pkg::DataOfs;
											i_q <= 6'd0; sub_q <= 2'd0; st_q <= S_DATAO;
										end else thisok_q <= 1'b1;
									end
								end
								PH_DATA: begin
									ph_q <= PH_ACK; cur_q <= dev_q + fbx_pkg::AckOfs;
									i_q <= 6'd0; sum_q <= 8'd1; sub_q <= 2'd0;
									st_q <= (rxc_q != 6'd0) ? S_FRD : S_ACKO;
								end
								PH_ACK: begin
									ph_q <= PH_IDLE; thisok_q <= 1'b1; i_q <= 6'd0;
									if (rxc_q != 6'd0) st_q <= S_HOLD;
								end
								default: ;
							endcase
						fbx_pkg::OpSyncByte: begin
							if (it.byte_index == 5'd0) sr0_q <= it.data_byte;
							if (it.byte_index == 5'd1) sr1_q <= it.data_byte;
						end
						fbx_pkg::OpBusErr: begin
							if (it.error_in_address_phase && cur_q == dev_q) online_q <= 1'b0;
							thisok_q <= 1'b0; sreq_q <= 1'b0; ph_q <= PH_IDLE;
						end
						default: ;
					endcase
				end
				S_QRD: if (i_q == n_q) begin
					stc_q <= n_q; txc_q <= n_q; sub_q <= 2'd0;
					qhead_q <= qhead_q + fbx_pkg::QAW'(n_q);
					qcnt_q <= qcnt_q - (fbx_pkg::QAW+1)'(n_q);
					st_q <= S_SYNCO;
				end else st_q <= S_QACC;
				S_QACC: begin
					sum_q <= sum_q + qrd_q; i_q <= i_q + 6'd1; st_q <= S_QRD;
				end
				S_SYNCO: if (ofree) begin
					ov_q <= 1'b1; ph_q <= PH_SYNC;
					case (sub_q)
						2'd0, 2'd1: begin
							ob_q <= mk(fbx_pkg::KindStart, fbx_pkg::MsgSync, dev_q, 6'd2, 6'd2,
								8'd0, 1'b0, online_q, sreq_q);
							sub_q <= 2'd2;
						end
						2'd2: begin
							ob_q <= mk(fbx_pkg::KindTx, 2'd0, 8'd0, 6'd0, 6'd0,
								8'(stc_q) + 8'd1, 1'b0, online_q, sreq_q);
							sub_q <= 2'd3;
						end
						default: begin
							ob_q <= mk(fbx_pkg::KindTx, 2'd0, 8'd0, 6'd0, 6'd0,
								8'(stc_q), 1'b1, online_q, sreq_q);
							st_q <= S_IDLE;
						end
					endcase
				end
				S_DATAO: if (ofree) begin
					ov_q <= 1'b1;
					if (sub_q == 2'd0) begin
						ob_q <= mk(fbx_pkg::KindStart, fbx_pkg::MsgData, cur_q,
							(txc_q != 6'd0) ? txc_q + 6'd1 : 6'd0,
							(rxc_q != 6'd0) ? rxc_q + 6'd1 : 6'd0,
							8'd0, txc_q == 6'd0, online_q, sreq_q);
						sub_q <= 2'd1;
						if (txc_q == 6'd0) st_q <= S_IDLE;
						else st_q <= S_FRD;
					end else begin
						ob_q <= mk(fbx_pkg::KindTx, 2'd0, 8'd0, 6'd0, 6'd0, frd_q,
							i_q == txc_q, online_q, sreq_q);
						i_q <= i_q + 6'd1;
						if (i_q == txc_q) st_q <= S_IDLE;
						else st_q <= S_FRD;
					end
				end
				S_FRD: st_q <= (ph_q == PH_DATA) ? S_DATAO : S_RXSUM;
				S_RXSUM: begin
					if (sub_q == 2'd0) begin
						sum_q <= sum_q + frd_q; i_q <= i_q + 6'd1;
						if (i_q + 6'd1 == rxc_q) begin
							i_q <= 6'd63; sub_q <= 2'd1;
						end
						st_q <= S_FRD;
					end else begin
						sub_q <= (frd_q != sum_q) ? 2'd3 : 2'd2;
						st_q <= S_ACKO;
					end
				end
				S_ACKO: if (ofree) begin
					ov_q <= 1'b1;
					if (sub_q[0] == 1'b0 && i_q != 6'd62) begin
						ob_q <= mk(fbx_pkg::KindStart, fbx_pkg::MsgAck, cur_q, 6'd1, 6'd0,
							8'd0, 1'b0, online_q, sreq_q);
						i_q <= 6'd62;
					end else if (sub_q == 2'd3 && i_q != 6'd62) begin
						ob_q <= mk(fbx_pkg::KindStart, fbx_pkg::MsgAck, cur_q, 6'd1, 6'd0,
							8'd0, 1'b0, online_q, sreq_q);
						i_q <= 6'd62;
					end else begin
						ob_q <= mk(fbx_pkg::KindTx, 2'd0, 8'd0, 6'd0, 6'd0,
							(sub_q == 2'd3) ? fbx_pkg::AckBad : fbx_pkg::AckGood,
							1'b1, online_q, sreq_q);
						st_q <= S_IDLE;
					end
				end
				S_HOLD: st_q <= S_RXO;
				S_RXO: if (ofree) begin
					ov_q <= 1'b1;
					ob_q <= mk(fbx_pkg::KindRx, 2'd0, 8'd0, 6'd0, 6'd0, frd_q,
						i_q + 6'd1 == rxc_q, online_q, sreq_q);
					i_q <= i_q + 6'd1;
					st_q <= (i_q + 6'd1 == rxc_q) ? S_IDLE : S_HOLD;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/fbx_checker.sv @@
// fbx_port_checker: port-level assertions for the exchange controller
// depends on fbx_pkg; bound to framed_byte_bus_exchange_ctrl
module fbx_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input fbx_pkg::out_item_t out_data
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted back to back");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind != 2'd3)
		else $error("bad kind");
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == fbx_pkg::KindRx |-> out_data.tx_len == 6'd0)
		else $error("rx result with length");
endmodule

bind framed_byte_bus_exchange_ctrl fbx_port_checker u_fbx_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ bench/fbx_checker.sv @@
// fbx_checker: watches the in, out and cfg channels of the exchange controller,
// predicts every result transfer and compares it; depends on fbx_pkg
module fbx_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  fbx_pkg::in_item_t   in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  fbx_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	output int                  fail_count,
	output int                  pending_count
);
	typedef enum logic [1:0] {PhIdle, PhSyncSent, PhDataSent, PhAckSent} phase_t;

	fbx_pkg::out_item_t exp_results[$];

	logic [7:0] dev_addr, cur_addr;
	phase_t phase;
	logic [7:0] queue_mem [fbx_pkg::TxQueueDepth];
	int q_head, q_count;
	logic [7:0] frame_tx [fbx_pkg::MaxFrame];
	logic [7:0] frame_rx [fbx_pkg::MaxFrame];
	logic [7:0] reply [2];
	int tx_cnt, rx_cnt, sync_cnt;
	bit online, last_ok, this_ok, sync_pend, start_req;
	fbx_pkg::out_item_t staged[$];

	function automatic fbx_pkg::out_item_t mk(logic [1:0] k, logic [1:0] t, logic [7:0] a,
			logic [5:0] tl, logic [5:0] rl, logic [7:0] b);
		fbx_pkg::out_item_t r;
		r = '0;
		r.kind = k;
		r.msg_type = t;
		r.address = a;
		r.tx_len = tl;
		r.rx_len = rl;
		r.data_byte_res = b;
		return r;
	endfunction

	task automatic open_sync();
		int n, sum;
		last_ok = this_ok;
		cur_addr = dev_addr;
		if (tx_cnt == 0 || this_ok) begin
			n = q_count;
			this_ok = 0;
			if (n > fbx_pkg::MaxFrame - 1)
				n = fbx_pkg::MaxFrame - 1;
			if (n != 0) begin
				sum = 1;
				for (int i = 0; i < n; i++) begin
					frame_tx[1 + i] = queue_mem[q_head];
					sum += queue_mem[q_head];
					q_head = (q_head + 1) % fbx_pkg::TxQueueDepth;
					q_count--;
				end
				frame_tx[0] = sum[7:0];
			end
			sync_cnt = n;
			tx_cnt = n;
		end else begin
			tx_cnt = sync_cnt;
		end
		phase = PhSyncSent;
		staged.push_back(mk(fbx_pkg::KindStart, fbx_pkg::MsgSync, cur_addr, 6'd2, 6'd2, 8'd0));
		staged.push_back(mk(fbx_pkg::KindTx, fbx_pkg::MsgSync, 8'd0, 6'd0, 6'd0,
			8'(sync_cnt + 1)));
		staged.push_back(mk(fbx_pkg::KindTx, fbx_pkg::MsgSync, 8'd0, 6'd0, 6'd0,
			8'(sync_cnt)));
	endtask

	task automatic finish_message();
		int r, txl, rxl, sum;
		logic [7:0] ack;
		case (phase)
			PhSyncSent: begin
				r = reply[1];
				online = 1;
				if (8'(r + 1) == reply[0]) begin
					if (r > fbx_pkg::MaxFrame - 1)
						r = fbx_pkg::MaxFrame - 1;
					rx_cnt = r;
					if (r != 0 || tx_cnt != 0) begin
						txl = tx_cnt != 0 ? tx_cnt + 1 : 0;
						rxl = r != 0 ? r + 1 : 0;
						cur_addr = dev_addr + fbx_pkg::DataOfs;
						phase = PhDataSent;
						staged.push_back(mk(fbx_pkg::KindStart, fbx_pkg::MsgData, cur_addr,
							6'(txl), 6'(rxl), 8'd0));
						for (int i = 0; i < txl; i++)
							staged.push_back(mk(fbx_pkg::KindTx, fbx_pkg::MsgSync, 8'd0, 6'd0,
								6'd0, frame_tx[i]));
					end else begin
						this_ok = 1;
						phase = PhIdle;
					end
				end else begin
					rx_cnt = r;
					phase = PhIdle;
				end
			end
			PhDataSent: begin
				ack = fbx_pkg::AckGood;
				cur_addr = dev_addr + fbx_pkg::AckOfs;
				if (rx_cnt != 0) begin
					sum = 1;
					for (int i = 0; i < rx_cnt; i++)
						sum += frame_rx[1 + i];
					if (frame_rx[0] != sum[7:0])
						ack = fbx_pkg::AckBad;
				end
				phase = PhAckSent;
				staged.push_back(mk(fbx_pkg::KindStart, fbx_pkg::MsgAck, cur_addr, 6'd1, 6'd0,
					8'd0));
				staged.push_back(mk(fbx_pkg::KindTx, fbx_pkg::MsgSync, 8'd0, 6'd0, 6'd0, ack));
			end
			PhAckSent: begin
				phase = PhIdle;
				this_ok = 1;
				for (int i = 0; i < rx_cnt; i++)
					staged.push_back(mk(fbx_pkg::KindRx, fbx_pkg::MsgSync, 8'd0, 6'd0, 6'd0,
						frame_rx[1 + i]));
			end
			default: ;
		endcase
	endtask

	task automatic predict_item(fbx_pkg::in_item_t it);
		fbx_pkg::out_item_t r;
		staged.delete();
		case (it.op)
			fbx_pkg::OpPush:
				if (q_count < fbx_pkg::TxQueueDepth) begin
					queue_mem[(q_head + q_count) % fbx_pkg::TxQueueDepth] = it.data_byte;
					q_count++;
				end
			fbx_pkg::OpSyncReq: begin
				sync_pend = 1;
				start_req = 1;
			end
			fbx_pkg::OpSlot: begin
				if (phase == PhIdle && sync_pend) begin
					sync_pend = 0;
					open_sync();
				end
				start_req = sync_pend;
			end
			fbx_pkg::OpDone: finish_message();
			fbx_pkg::OpSyncByte:
				if (it.byte_index < 2)
					reply[it.byte_index[0]] = it.data_byte;
			fbx_pkg::OpDataByte: frame_rx[it.byte_index] = it.data_byte;
			fbx_pkg::OpBusErr: begin
				if (it.error_in_address_phase && cur_addr == dev_addr)
					online = 0;
				this_ok = 0;
				start_req = 0;
				phase = PhIdle;
			end
			default: ;
		endcase
		foreach (staged[k]) begin
			r = staged[k];
			r.last = (k == staged.size() - 1);
			r.online = online;
			r.start_request = start_req;
			exp_results.push_back(r);
		end
	endtask

	task automatic compare_result(fbx_pkg::out_item_t got);
		fbx_pkg::out_item_t e;
		if (exp_results.size() == 0) begin
			$error("unexpected result transfer %h", got);
			fail_count++;
			return;
		end
		e = exp_results.pop_front();
		if (got.kind != e.kind) begin
			$error("kind exp %0d got %0d", e.kind, got.kind); fail_count++;
		end
		if (got.msg_type != e.msg_type) begin
			$error("msg_type exp %0d got %0d", e.msg_type, got.msg_type); fail_count++;
		end
		if (got.address != e.address) begin
			$error("address exp %h got %h", e.address, got.address); fail_count++;
		end
		if (got.tx_len != e.tx_len) begin
			$error("tx_len exp %0d got %0d", e.tx_len, got.tx_len); fail_count++;
		end
		if (got.rx_len != e.rx_len) begin
			$error("rx_len exp %0d got %0d", e.rx_len, got.rx_len); fail_count++;
		end
		if (got.data_byte_res != e.data_byte_res) begin
			$error("data_byte_res exp %h got %h", e.data_byte_res, got.data_byte_res);
			fail_count++;
		end
		if (got.last != e.last) begin
			$error("last exp %0d got %0d", e.last, got.last); fail_count++;
		end
		if (got.online != e.online) begin
			$error("online exp %0d got %0d", e.online, got.online); fail_count++;
		end
		if (got.start_request != e.start_request) begin
			$error("start_request exp %0d got %0d", e.start_request, got.start_request);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
		dev_addr = '0;
		cur_addr = '0;
		phase = PhIdle;
		q_head = 0;
		q_count = 0;
		reply[0] = '0;
		reply[1] = '0;
		tx_cnt = 0;
		rx_cnt = 0;
		sync_cnt = 0;
		online = 0;
		last_ok = 1;
		this_ok = 1;
		sync_pend = 0;
		start_req = 0;
		foreach (frame_rx[i])
			frame_rx[i] = '0;
		foreach (frame_tx[i])
			frame_tx[i] = '0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				compare_result(out_data);
			if (cfg_valid && cfg_ready) begin
				dev_addr = cfg_data;
				cur_addr = cfg_data;
			end
			if (in_valid && in_ready)
				predict_item(in_data);
			pending_count = exp_results.size();
		end
	end
endmodule

@@ bench/framed_byte_bus_exchange_ctrl_test.sv @@
// framed_byte_bus_exchange_ctrl_test: stimulus and verdict for the exchange controller
// depends on fbx_pkg, fbx_checker and framed_byte_bus_exchange_ctrl
module framed_byte_bus_exchange_ctrl_test;
	localparam logic [2:0] OpUnused = 3'd7;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	fbx_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	fbx_pkg::out_item_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;
	int fail_count, pending_count;
	int cycle_count = 0;
	bit hold_off = 0;

	framed_byte_bus_exchange_ctrl u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	fbx_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always #10 clk = ~clk;

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
	endfunction

	// valid drops only when a gap follows, so a back-to-back transfer reassigns once
	task automatic send(logic [2:0] op, logic [7:0] b, logic [4:0] idx, logic ap);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 0;
			repeat (g)
				@(posedge clk);
		end
		in_data <= '{op: op, data_byte: b, byte_index: idx, error_in_address_phase: ap};
		in_valid <= 1;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic write_addr(logic [7:0] a);
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		cfg_data <= a;
		cfg_valid <= 1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// a full exchange: sync, reply, data frame, ack, delivery
	task automatic exchange(int rxn, bit good_sum, bit good_chk);
		int sum;
		logic [7:0] b;
		send(fbx_pkg::OpSyncReq, 8'($urandom), 5'($urandom), 1'($urandom));
		send(fbx_pkg::OpSlot, 8'($urandom), 5'($urandom), 1'($urandom));
		send(fbx_pkg::OpSyncByte, good_chk ? 8'(rxn + 1) : 8'(rxn + 2), 5'd0, 1'($urandom));
		send(fbx_pkg::OpSyncByte, 8'(rxn), 5'd1, 1'($urandom));
		sum = 1;
		for (int i = 1; i <= rxn; i++) begin
			b = 8'($urandom);
			sum += b;
			send(fbx_pkg::OpDataByte, b, 5'(i), 1'($urandom));
		end
		send(fbx_pkg::OpDataByte, good_sum ? 8'(sum) : 8'(sum + 1), 5'd0, 1'($urandom));
		send(fbx_pkg::OpDone, 8'($urandom), 5'($urandom), 1'($urandom));
		send(fbx_pkg::OpDone, 8'($urandom), 5'($urandom), 1'($urandom));
		send(fbx_pkg::OpDone, 8'($urandom), 5'($urandom), 1'($urandom));
	endtask

	// receiver side
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 0;
		else if ($urandom_range(0, 19) == 0)
			out_ready <= 0;
		else
			out_ready <= $urandom_range(0, 3) != 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 8; i++)
			send(fbx_pkg::OpPush, i[0] ? 8'hFF : 8'h00, 5'd31, 1);
		exchange(3, 1, 1);
		// writes every reply entry before any later exchange reads it
		exchange(31, 0, 1);
		exchange(0, 1, 1);
		exchange(2, 1, 0);
		send(fbx_pkg::OpDone, 8'h00, 5'd0, 0);
		send(fbx_pkg::OpSlot, 8'h00, 5'd0, 0);
		send(OpUnused, 8'hFF, 5'd31, 1);
		send(fbx_pkg::OpSyncByte, 8'hAA, 5'd31, 0);
		write_addr(8'hFF);
		for (int i = 0; i < 32; i++)
			send(fbx_pkg::OpPush, 8'($urandom), 5'($urandom), 1'($urandom));
		exchange(5, 1, 1);
		send(fbx_pkg::OpSyncReq, 8'h00, 5'd0, 0);
		send(fbx_pkg::OpSlot, 8'h00, 5'd0, 0);
		send(fbx_pkg::OpBusErr, 8'h00, 5'd0, 1);
		send(fbx_pkg::OpSlot, 8'h00, 5'd0, 0);
		send(fbx_pkg::OpBusErr, 8'h00, 5'd0, 0);
		// long receiver stall while offering items
		fork
			begin
				hold_off = 1;
				repeat (400)
					@(posedge clk);
				hold_off = 0;
			end
			exchange(4, 1, 1);
		join
		write_addr(8'h5A);
		for (int n = 0; n < 2; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send(3'($urandom_range(0, 7)), 8'($urandom), 5'($urandom),
						1'($urandom));
			end else begin
				repeat ($urandom_range(0, 3))
					send(fbx_pkg::OpPush, 8'($urandom), 5'($urandom), 1'($urandom));
				exchange($urandom_range(0, 6), $urandom_range(0, 3) != 0,
					$urandom_range(0, 5) != 0);
			end
			if (n == 0)
				write_addr(8'($urandom));
		end
		write_addr(8'h80);
		exchange(2, 1, 1);
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ files.f @@
src/fbx_pkg.sv
src/framed_byte_bus_exchange_ctrl.sv
src/fbx_checker.sv
bench/fbx_checker.sv
bench/framed_byte_bus_exchange_ctrl_test.sv
